// ===== src/frp_pkg.sv =====
package frp_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;
  localparam int STAT_W = 2;
  localparam int REG_W  = 2;

  localparam logic [STAT_W-1:0] ST_GOOD    = 2'd0;
  localparam logic [STAT_W-1:0] ST_LEN_ERR = 2'd1;
  localparam logic [STAT_W-1:0] ST_CHK_ERR = 2'd2;
  localparam logic [STAT_W-1:0] ST_END_ERR = 2'd3;

  localparam logic [REG_W-1:0] REG_START_BYTE = 2'd0;
  localparam logic [REG_W-1:0] REG_END_BYTE   = 2'd1;
  localparam logic [REG_W-1:0] REG_MAX_LEN    = 2'd2;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd2;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'd3;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST    = 6'd32;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] length;
    logic              has_payload;
    logic              bank;
  } job_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [LEN_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

endpackage

// ===== src/framed_packet_receiver.sv =====
// Parses a byte stream into frames of start byte, command, length, payload,
// checksum and end byte, where the checksum is the XOR of command, length,
// payload and end byte. The parser takes one byte per clock; full rises only
// while two finished frames wait in the job queue, or while a payload byte
// would land in a buffer bank whose previous frame is still being emitted.
// A good frame comes out as one result per payload byte, each byte read from
// the buffer in B_READ and then loaded into the output register in B_SEND,
// or as a single result when its length is zero. Length, checksum and end
// marker errors give one result each, loaded into the output register once it
// is free after they reach the head of the job queue. The last result of every
// run has last set. The payload buffer holds two banks of MAX_PAYLOAD bytes,
// so the parser can fill one frame while the previous one drains.
module framed_packet_receiver #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [frp_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                        wr_en,
  input  logic [frp_pkg::REG_W-1:0]   wr_index,
  input  logic [frp_pkg::BYTE_W-1:0]  wr_data,
  output logic                        empty,
  input  logic                        pop,
  output logic [frp_pkg::STAT_W-1:0]  status,
  output logic [frp_pkg::BYTE_W-1:0]  command,
  output logic [frp_pkg::BYTE_W-1:0]  length,
  output logic [frp_pkg::BYTE_W-1:0]  payload_byte,
  output logic                        payload_valid,
  output logic                        last
);
  import frp_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  job_t q_in, q_head;
  wr_t  mem_wr;
  rel_t rel;

  frp_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .rx_byte  (rx_byte),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_in),
    .mem_wr   (mem_wr),
    .rel      (rel)
  );

  frp_jobq u_jobq (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_in    (q_in),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  frp_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk           (clk),
    .rst           (rst),
    .mem_wr        (mem_wr),
    .job_valid     (~q_empty),
    .job           (q_head),
    .job_pop       (q_pop),
    .rel           (rel),
    .empty         (empty),
    .pop           (pop),
    .status        (status),
    .command       (command),
    .length        (length),
    .payload_byte  (payload_byte),
    .payload_valid (payload_valid),
    .last          (last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job queue read while empty");

  a_payload_good: assert property (@(posedge clk) disable iff (rst)
    (!empty && payload_valid) |-> (status == ST_GOOD))
    else $error("payload beat carries an error status");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_GOOD) |-> (last && !payload_valid))
    else $error("error beat is not a single closing beat");

endmodule

// ===== src/frp_front.sv =====
module frp_front #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [frp_pkg::BYTE_W-1:0] rx_byte,
  input  logic                      wr_en,
  input  logic [frp_pkg::REG_W-1:0] wr_index,
  input  logic [frp_pkg::BYTE_W-1:0] wr_data,
  input  logic                      q_full,
  output logic                      q_push,
  output frp_pkg::job_t             q_job,
  output frp_pkg::wr_t              mem_wr,
  input  frp_pkg::rel_t             rel
);
  import frp_pkg::*;

  localparam logic [BYTE_W-1:0] MAX8 = BYTE_W'(MAX_PAYLOAD);

  typedef enum logic [5:0] {
    P_START = 6'b000001,
    P_CMD   = 6'b000010,
    P_LEN   = 6'b000100,
    P_DATA  = 6'b001000,
    P_CHK   = 6'b010000,
    P_END   = 6'b100000
  } phase_t;

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] start_byte, end_byte;
  logic [LEN_W-1:0]  max_len;
  logic [BYTE_W-1:0] frame_command, frame_command_next;
  logic [LEN_W-1:0]  frame_length, frame_length_next;
  logic [LEN_W-1:0]  payload_index, payload_index_next;
  logic [BYTE_W-1:0] received_checksum, received_checksum_next;
  logic [BYTE_W-1:0] running_checksum, running_checksum_next;
  logic              wbank, wbank_next;
  logic [1:0]        held, held_next;
  logic              accept;
  logic [BYTE_W-1:0] limit;

  assign full   = q_full | ((phase == P_DATA) & held[wbank]);
  assign accept = push & ~full;
  assign limit  = ({2'b00, max_len} < MAX8) ? {2'b00, max_len} : MAX8;

  always_comb begin
    phase_next             = phase;
    frame_command_next     = frame_command;
    frame_length_next      = frame_length;
    payload_index_next     = payload_index;
    received_checksum_next = received_checksum;
    running_checksum_next  = running_checksum;
    wbank_next             = wbank;
    held_next              = held;
    q_push                 = 1'b0;
    q_job                  = '0;
    mem_wr                 = '0;
    if (rel.en) begin
      held_next[rel.bank] = 1'b0;
    end
    if (accept) begin
      case (phase)
        P_CMD: begin
          frame_command_next    = rx_byte;
          running_checksum_next = rx_byte;
          phase_next            = P_LEN;
        end
        P_LEN: begin
          payload_index_next = '0;
          if (rx_byte > limit) begin
            q_push         = 1'b1;
            q_job.status   = ST_LEN_ERR;
            q_job.command  = frame_command;
            q_job.length   = rx_byte;
            phase_next     = P_START;
          end else begin
            frame_length_next     = rx_byte[LEN_W-1:0];
            running_checksum_next = running_checksum ^ rx_byte;
            phase_next            = (rx_byte != '0) ? P_DATA : P_CHK;
          end
        end
        P_DATA: begin
          mem_wr.en             = 1'b1;
          mem_wr.bank           = wbank;
          mem_wr.idx            = payload_index;
          mem_wr.data           = rx_byte;
          running_checksum_next = running_checksum ^ rx_byte;
          payload_index_next    = payload_index + 1'b1;
          if (payload_index_next >= frame_length) begin
            phase_next = P_CHK;
          end
        end
        P_CHK: begin
          received_checksum_next = rx_byte;
          phase_next             = P_END;
        end
        P_END: begin
          q_push        = 1'b1;
          q_job.command = frame_command;
          q_job.length  = {2'b00, frame_length};
          if (rx_byte != end_byte) begin
            q_job.status = ST_END_ERR;
          end else if ((running_checksum ^ rx_byte) != received_checksum) begin
            q_job.status = ST_CHK_ERR;
          end else begin
            q_job.status = ST_GOOD;
            if (frame_length != '0) begin
              q_job.has_payload = 1'b1;
              q_job.bank        = wbank;
              held_next[wbank]  = 1'b1;
              wbank_next        = ~wbank;
            end
          end
          phase_next = P_START;
        end
        default: begin
          phase_next = (rx_byte == start_byte) ? P_CMD : P_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= P_START;
      frame_command     <= '0;
      frame_length      <= '0;
      payload_index     <= '0;
      received_checksum <= '0;
      running_checksum  <= '0;
      wbank             <= 1'b0;
      held              <= '0;
    end else begin
      phase             <= phase_next;
      frame_command     <= frame_command_next;
      frame_length      <= frame_length_next;
      payload_index     <= payload_index_next;
      received_checksum <= received_checksum_next;
      running_checksum  <= running_checksum_next;
      wbank             <= wbank_next;
      held              <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RST;
      end_byte   <= END_BYTE_RST;
      max_len    <= MAX_LEN_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_START_BYTE: start_byte <= wr_data;
        REG_END_BYTE:   end_byte   <= wr_data;
        REG_MAX_LEN:    max_len    <= wr_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/frp_jobq.sv =====
module frp_jobq (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_push,
  input  frp_pkg::job_t q_in,
  output logic          q_full,
  input  logic          q_pop,
  output logic          q_empty,
  output frp_pkg::job_t q_head
);
  import frp_pkg::*;

  job_t       entries [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign q_head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (q_push) begin
      entries[wptr] <= q_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (q_push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, q_push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== src/frp_back.sv =====
module frp_back #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  frp_pkg::wr_t                mem_wr,
  input  logic                        job_valid,
  input  frp_pkg::job_t               job,
  output logic                        job_pop,
  output frp_pkg::rel_t               rel,
  output logic                        empty,
  input  logic                        pop,
  output logic [frp_pkg::STAT_W-1:0]  status,
  output logic [frp_pkg::BYTE_W-1:0]  command,
  output logic [frp_pkg::BYTE_W-1:0]  length,
  output logic [frp_pkg::BYTE_W-1:0]  payload_byte,
  output logic                        payload_valid,
  output logic                        last
);
  import frp_pkg::*;

  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_SEND = 3'b100
  } bstate_t;

  logic [BYTE_W-1:0] mem [2][MAX_PAYLOAD];
  logic [BYTE_W-1:0] rd_data;
  bstate_t           state, state_next;
  logic [LEN_W-1:0]  idx, idx_next;
  logic              out_valid, out_free, load, is_last;
  logic [STAT_W-1:0] ld_status;
  logic [BYTE_W-1:0] ld_byte;
  logic              ld_pvalid, ld_last;

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.bank][mem_wr.idx[IDX_W-1:0]] <= mem_wr.data;
    end
    rd_data <= mem[job.bank][idx[IDX_W-1:0]];
  end

  assign out_free = ~out_valid | pop;
  assign empty    = ~out_valid;
  assign is_last  = (LEN_W'(idx + 1'b1) == job.length[LEN_W-1:0]);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    load       = 1'b0;
    job_pop    = 1'b0;
    rel        = '0;
    ld_status  = job.status;
    ld_byte    = '0;
    ld_pvalid  = 1'b0;
    ld_last    = 1'b1;
    case (state)
      B_IDLE: begin
        if (job_valid) begin
          if (!job.has_payload) begin
            if (out_free) begin
              load    = 1'b1;
              job_pop = 1'b1;
            end
          end else begin
            idx_next   = '0;
            state_next = B_READ;
          end
        end
      end
      B_READ: begin
        state_next = B_SEND;
      end
      B_SEND: begin
        if (out_free) begin
          load      = 1'b1;
          ld_status = ST_GOOD;
          ld_byte   = rd_data;
          ld_pvalid = 1'b1;
          ld_last   = is_last;
          idx_next  = idx + 1'b1;
          if (is_last) begin
            job_pop    = 1'b1;
            rel.en     = 1'b1;
            rel.bank   = job.bank;
            state_next = B_IDLE;
          end else begin
            state_next = B_READ;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= load | (out_valid & ~pop);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status        <= ld_status;
      command       <= job.command;
      length        <= job.length;
      payload_byte  <= ld_byte;
      payload_valid <= ld_pvalid;
      last          <= ld_last;
    end
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import frp_pkg::*;

  localparam int BUF_DEPTH    = 32;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_BYTES  = 100;

  typedef enum logic [2:0] {PH_IDLE, PH_CMD, PH_LEN, PH_DATA, PH_CHK, PH_END} parse_phase_t;
  typedef enum int {FLAW_NONE, FLAW_CHK, FLAW_END, FLAW_BOTH} frame_flaw_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] length;
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    logic              last;
  } frame_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic              wr_en = 1'b0;
  logic [REG_W-1:0]  wr_index = REG_START_BYTE;
  logic [BYTE_W-1:0] wr_data = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [STAT_W-1:0] res_status;
  logic [BYTE_W-1:0] res_command;
  logic [BYTE_W-1:0] res_length;
  logic [BYTE_W-1:0] res_payload_byte;
  logic              res_payload_valid;
  logic              res_last;

  framed_packet_receiver #(.MAX_PAYLOAD(BUF_DEPTH)) uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .empty        (empty),
    .pop          (pop),
    .status       (res_status),
    .command      (res_command),
    .length       (res_length),
    .payload_byte (res_payload_byte),
    .payload_valid(res_payload_valid),
    .last         (res_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Register mirror and parser state of the expected behavior.
  logic [BYTE_W-1:0] cfg_start = START_BYTE_RST;
  logic [BYTE_W-1:0] cfg_end = END_BYTE_RST;
  logic [LEN_W-1:0]  cfg_max_len = MAX_LEN_RST;
  parse_phase_t      ph = PH_IDLE;
  logic [BYTE_W-1:0] f_cmd = '0;
  logic [BYTE_W-1:0] f_len = '0;
  int                f_idx = 0;
  logic [BYTE_W-1:0] rx_chk = '0;
  logic [BYTE_W-1:0] run_chk = '0;
  logic [BYTE_W-1:0] frame_buf [BUF_DEPTH];

  frame_result_t     frame_results[$];
  logic [BYTE_W-1:0] rx_pending[$];
  int                bytes_queued = 0;
  int                bytes_taken = 0;
  int                mismatches = 0;
  int                src_wait = 0;
  int                sink_wait = 0;
  bit                no_idle = 1'b0;
  bit                in_beat = 1'b0;
  bit                out_beat = 1'b0;
  frame_result_t     got;
  frame_result_t     want;

  function automatic int buffer_limit();
    return (cfg_max_len < BUF_DEPTH) ? int'(cfg_max_len) : BUF_DEPTH;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
    case (ph)
      PH_CMD: begin
        f_cmd = b;
        run_chk = b;
        ph = PH_LEN;
      end
      PH_LEN: begin
        f_idx = 0;
        if (b > buffer_limit()) begin
          frame_results.push_back('{ST_LEN_ERR, f_cmd, b, 8'h00, 1'b0, 1'b1});
          ph = PH_IDLE;
        end else begin
          f_len = b;
          run_chk ^= b;
          ph = (b != 0) ? PH_DATA : PH_CHK;
        end
      end
      PH_DATA: begin
        frame_buf[f_idx] = b;
        run_chk ^= b;
        f_idx++;
        if (f_idx >= f_len) ph = PH_CHK;
      end
      PH_CHK: begin
        rx_chk = b;
        ph = PH_END;
      end
      PH_END: begin
        if (b != cfg_end) begin
          frame_results.push_back('{ST_END_ERR, f_cmd, f_len, 8'h00, 1'b0, 1'b1});
        end else if ((run_chk ^ b) != rx_chk) begin
          frame_results.push_back('{ST_CHK_ERR, f_cmd, f_len, 8'h00, 1'b0, 1'b1});
        end else if (f_len == 0) begin
          frame_results.push_back('{ST_GOOD, f_cmd, 8'h00, 8'h00, 1'b0, 1'b1});
        end else begin
          for (int i = 0; i < f_len; i++)
            frame_results.push_back('{ST_GOOD, f_cmd, f_len, frame_buf[i], 1'b1,
                                      1'(i + 1 == f_len)});
        end
        ph = PH_IDLE;
      end
      default: ph = (b == cfg_start) ? PH_CMD : PH_IDLE;
    endcase
  endtask

  always @(posedge clk) begin
    in_beat = 1'b0;
    out_beat = 1'b0;
    if (!rst) begin
      if ($urandom_range(0, 199) == 0) no_idle = !no_idle;
      if (push && !full) begin
        in_beat = 1'b1;
        bytes_taken++;
        parse_rx_byte(rx_byte);
      end
      if (pop && !empty) begin
        out_beat = 1'b1;
        got = {res_status, res_command, res_length, res_payload_byte,
               res_payload_valid, res_last};
        if (frame_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected beat st=%0d cmd=%h len=%0d byte=%h pv=%b last=%b",
                     $realtime, got.status, got.command, got.length, got.payload_byte,
                     got.payload_valid, got.last);
        end else begin
          want = frame_results.pop_front();
          if (got.status !== want.status || got.command !== want.command ||
              got.length !== want.length || got.payload_byte !== want.payload_byte ||
              got.payload_valid !== want.payload_valid || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch, expected st=%0d cmd=%h len=%0d byte=%h pv=%b last=%b",
                       $realtime, want.status, want.command, want.length,
                       want.payload_byte, want.payload_valid, want.last);
              $display("%0t:           actual   st=%0d cmd=%h len=%0d byte=%h pv=%b last=%b",
                       $realtime, got.status, got.command, got.length,
                       got.payload_byte, got.payload_valid, got.last);
            end
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || in_beat) begin
      if (in_beat) src_wait = draw_gap();
      if (src_wait > 0) begin
        src_wait--;
        push <= 1'b0;
      end else if (rx_pending.size() != 0) begin
        push <= 1'b1;
        rx_byte <= rx_pending.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (out_beat) sink_wait = draw_gap();
      if (sink_wait > 0) begin
        sink_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic void queue_byte(input logic [BYTE_W-1:0] b);
    rx_pending.push_back(b);
    bytes_queued++;
  endfunction

  // A fill below zero gives a random payload.
  function automatic void add_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] len,
                                    input frame_flaw_t flaw, input int fill);
    logic [BYTE_W-1:0] chk;
    logic [BYTE_W-1:0] body;
    queue_byte(cfg_start);
    queue_byte(cmd);
    queue_byte(len);
    if (len > buffer_limit()) return;
    chk = cmd ^ len ^ cfg_end;
    for (int i = 0; i < len; i++) begin
      body = (fill < 0) ? 8'($urandom) : 8'(fill);
      chk ^= body;
      queue_byte(body);
    end
    if (flaw == FLAW_CHK || flaw == FLAW_BOTH) chk ^= 8'($urandom_range(1, 255));
    queue_byte(chk);
    if (flaw == FLAW_END || flaw == FLAW_BOTH)
      queue_byte(cfg_end ^ 8'($urandom_range(1, 255)));
    else
      queue_byte(cfg_end);
  endfunction

  function automatic void add_random_traffic(input int budget);
    int target;
    int pick;
    int sel;
    int lim;
    int len;
    target = bytes_queued + budget;
    while (bytes_queued < target) begin
      pick = $urandom_range(0, 99);
      sel = $urandom_range(0, 19);
      lim = buffer_limit();
      if (sel == 0) len = lim;
      else if (sel < 3) len = $urandom_range(0, lim);
      else len = $urandom_range(0, (lim < 8) ? lim : 8);
      if (pick < 72) begin
        add_frame(8'($urandom), 8'(len), FLAW_NONE, -1);
      end else if (pick < 80) begin
        add_frame(8'($urandom), 8'(len), FLAW_CHK, -1);
      end else if (pick < 86) begin
        add_frame(8'($urandom), 8'(len), FLAW_END, -1);
      end else if (pick < 89) begin
        add_frame(8'($urandom), 8'(len), FLAW_BOTH, -1);
      end else if (pick < 93) begin
        add_frame(8'($urandom), 8'($urandom_range(lim + 1, 255)), FLAW_NONE, -1);
      end else if (pick < 96) begin
        queue_byte(cfg_start);
        repeat ($urandom_range(0, 3)) queue_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      end
    end
  endfunction

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [BYTE_W-1:0] data);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    case (idx)
      REG_START_BYTE: cfg_start = data;
      REG_END_BYTE:   cfg_end = data;
      REG_MAX_LEN:    cfg_max_len = data[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (bytes_taken != bytes_queued || frame_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [BYTE_W-1:0] set_start [5];
    logic [BYTE_W-1:0] set_end [5];
    logic [BYTE_W-1:0] set_max [5];
    set_start = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), START_BYTE_RST};
    set_end   = '{8'hFF, 8'h00, 8'($urandom), 8'($urandom), END_BYTE_RST};
    set_max   = '{8'd0, 8'd32, 8'($urandom_range(1, 31)), 8'd63, 8'(MAX_LEN_RST)};
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    add_frame(START_BYTE_RST, 8'd0, FLAW_NONE, -1);
    add_frame(8'hFF, 8'd33, FLAW_NONE, -1);
    add_frame(8'h00, 8'd255, FLAW_NONE, -1);
    add_frame(8'h80, 8'd2, FLAW_NONE, 8'hFF);
    add_frame(8'h5A, 8'd1, FLAW_CHK, 8'h00);
    add_frame(8'hA5, 8'd0, FLAW_END, -1);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_reg(REG_START_BYTE, set_start[p]);
      write_reg(REG_END_BYTE, set_end[p]);
      write_reg(REG_MAX_LEN, set_max[p]);
      add_random_traffic(PHASE_BYTES);
      wait_drained();
    end

    if (mismatches == 0 && frame_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
